FILE: rtl/core/mqd_pkg.sv
// Shared types, constants and probability tables for the MQ decoder.
package mqd_pkg;

    localparam int NUM_CONTEXTS = 32;
    localparam int BUF_BYTES    = 4096;

    localparam int BUF_AW  = $clog2(BUF_BYTES);
    localparam int CNT_W   = BUF_AW + 1;
    localparam int CTX_AW  = $clog2(NUM_CONTEXTS);
    localparam int ENTRY_W = 7;

    localparam logic [1:0] OP_DECODE = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;
    localparam logic [1:0] OP_START  = 2'd3;

    localparam logic [23:0] INTERVAL_MIN = 24'h800000;
    localparam logic [5:0]  LAST_STATE   = 6'd46;
    localparam logic [8:0]  BYTE_FF      = 9'h0FF;
    localparam logic [7:0]  MARKER_MIN   = 8'h8F;
    localparam logic [4:0]  MAX_SHIFTS   = 5'd24;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] context_index;
        logic [7:0] code_byte;
        logic [5:0] prob_index;
        logic       mps_bit;
    } t_in_item;

    typedef struct packed {
        logic        decision;
        logic [15:0] marker_count;
    } t_out_item;

    typedef struct packed {
        logic               rd_en;
        logic [CTX_AW-1:0]  rd_addr;
        logic               wr_en;
        logic [CTX_AW-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
    } t_ctx_req;

    typedef struct packed {
        logic              rd_en;
        logic [BUF_AW-1:0] rd_addr;
        logic              wr_en;
        logic [BUF_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
    } t_byte_req;

    localparam logic [15:0] QE_TAB [0:46] = '{
        16'h5601, 16'h3401, 16'h1801, 16'h0AC1, 16'h0521, 16'h0221, 16'h5601, 16'h5401,
        16'h4801, 16'h3801, 16'h3001, 16'h2401, 16'h1C01, 16'h1601, 16'h5601, 16'h5401,
        16'h5101, 16'h4801, 16'h3801, 16'h3401, 16'h3001, 16'h2801, 16'h2401, 16'h2201,
        16'h1C01, 16'h1801, 16'h1601, 16'h1401, 16'h1201, 16'h1101, 16'h0AC1, 16'h09C1,
        16'h08A1, 16'h0521, 16'h0441, 16'h02A1, 16'h0221, 16'h0141, 16'h0111, 16'h0085,
        16'h0049, 16'h0025, 16'h0015, 16'h0009, 16'h0005, 16'h0001, 16'h5601
    };

    localparam logic [5:0] NMPS_TAB [0:46] = '{
        6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd38, 6'd7,  6'd8,  6'd9,  6'd10,
        6'd11, 6'd12, 6'd13, 6'd29, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20,
        6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30,
        6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40,
        6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd45, 6'd46
    };

    localparam logic [5:0] NLPS_TAB [0:46] = '{
        6'd1,  6'd6,  6'd9,  6'd12, 6'd29, 6'd33, 6'd6,  6'd14, 6'd14, 6'd14,
        6'd17, 6'd18, 6'd20, 6'd21, 6'd14, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18,
        6'd19, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37,
        6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd46
    };

    // MPS flips on an LPS only in the three equiprobable entry states
    function automatic logic swap_mps(input logic [5:0] idx);
        swap_mps = (idx == 6'd0) || (idx == 6'd6) || (idx == 6'd14);
    endfunction

endpackage

FILE: rtl/core/mqd_ctx_ram.sv
// Context state memory: probability index and MPS per context, zero after reset.
module mqd_ctx_ram (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mqd_pkg::t_ctx_req                 i_req,
    output logic [mqd_pkg::ENTRY_W-1:0]       o_rd_data
);
    import mqd_pkg::*;

    logic [ENTRY_W-1:0]      mem [0:NUM_CONTEXTS-1];
    logic [NUM_CONTEXTS-1:0] r_valid;
    logic [ENTRY_W-1:0]      r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: rtl/core/mqd_byte_ram.sv
// Compressed byte buffer: one write port, one registered read port.
module mqd_byte_ram (
    input  logic               i_clk,
    input  mqd_pkg::t_byte_req i_req,
    output logic [7:0]         o_rd_data
);
    import mqd_pkg::*;

    logic [7:0] mem [0:BUF_BYTES-1];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/mq_arithmetic_decoder_core.sv
// MQ arithmetic decoder top level: command sequencer, coder registers and memories.
// Append byte and set context: never busy, result strobe on the next cycle.
// Start: refill in phases PH_INIT1 then PH_INIT2, then the result strobes.
// Decode: context read, decision in S_DEC, then renormalization shifts in S_SHIFT
// with byte refills via the byte buffer read port (S_RF_USE); result strobe registered.
// A new word may be started in the cycle its predecessor's result strobes.
// Synchronous reset clears the coder registers, byte count and all context states.
module mq_arithmetic_decoder_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mqd_pkg::t_in_item i_item,
    output logic              o_strobe,
    output mqd_pkg::t_out_item o_result
);
    import mqd_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DEC    = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_RF_USE = 2'd3;

    localparam logic [1:0] PH_INIT1  = 2'd0;
    localparam logic [1:0] PH_INIT2  = 2'd1;
    localparam logic [1:0] PH_RENORM = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_phase, n_phase;
    logic [23:0]      r_a, n_a;
    logic [31:0]      r_c, n_c;
    logic [3:0]       r_ct, n_ct;
    logic [8:0]       r_b, n_b;
    logic [15:0]      r_markers, n_markers;
    logic [CNT_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_loaded, n_loaded;
    logic [4:0]       r_n, n_n;
    logic             r_dec, n_dec;
    t_in_item         r_item, n_item;
    logic             r_strobe, n_strobe;
    t_out_item        r_result, n_result;

    t_ctx_req           ctx_req;
    t_byte_req          byte_req;
    logic [ENTRY_W-1:0] ctx_rd;
    logic [7:0]         byte_rd;

    // refill path
    logic             rf_avail;
    logic [7:0]       rf_nb;
    logic [8:0]       rf_b;
    logic [3:0]       rf_ct;
    logic [15:0]      rf_mk;
    logic [CNT_W-1:0] rf_rp;
    logic [31:0]      rf_c;

    // shift path
    logic [31:0] sh_c_in;
    logic [3:0]  sh_ct_in;
    logic [23:0] sh_a;
    logic [31:0] sh_c;
    logic [3:0]  sh_ct;
    logic [4:0]  sh_n;
    logic        sh_done;

    // decision path
    logic [5:0]  dc_idx;
    logic        dc_mps;
    logic [23:0] dc_qe;
    logic [23:0] dc_asub;
    logic        dc_lps;
    logic        dc_move;
    logic        dc_ctx_ok;

    mqd_ctx_ram u_ctx_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ctx_req),
        .o_rd_data (ctx_rd)
    );

    mqd_byte_ram u_byte_ram (
        .i_clk     (i_clk),
        .i_req     (byte_req),
        .o_rd_data (byte_rd)
    );

    always_comb begin
        rf_avail = r_rp < r_loaded;
        rf_nb    = rf_avail ? byte_rd : 8'hFF;
        rf_b     = r_b;
        rf_ct    = 4'd8;
        rf_mk    = r_markers;
        rf_rp    = r_rp;
        if (r_b == BYTE_FF) begin
            if (rf_nb > MARKER_MIN) begin
                // marker: byte stays unread, feed ones
                if (r_markers != 16'hFFFF) begin
                    rf_mk = r_markers + 16'd1;
                end
            end else begin
                rf_b  = {rf_nb, 1'b0};
                rf_ct = 4'd7;
                if (rf_avail) begin
                    rf_rp = r_rp + CNT_W'(1);
                end
            end
        end else begin
            rf_b = {1'b0, rf_nb};
            if (rf_avail) begin
                rf_rp = r_rp + CNT_W'(1);
            end
        end
        rf_c = r_c + 32'(rf_b);
    end

    always_comb begin
        sh_c_in  = (r_state == S_RF_USE) ? rf_c : r_c;
        sh_ct_in = (r_state == S_RF_USE) ? rf_ct : r_ct;
        sh_a     = {r_a[22:0], 1'b0};
        sh_c     = {sh_c_in[30:0], 1'b0};
        sh_ct    = sh_ct_in - 4'd1;
        sh_n     = r_n + 5'd1;
        sh_done  = !((sh_a < INTERVAL_MIN) && (sh_n < MAX_SHIFTS));
    end

    always_comb begin
        dc_idx    = (ctx_rd[5:0] > LAST_STATE) ? LAST_STATE : ctx_rd[5:0];
        dc_mps    = ctx_rd[6];
        dc_qe     = {QE_TAB[dc_idx], 8'h00};
        dc_asub   = r_a - dc_qe;
        dc_ctx_ok = int'(i_item.context_index) < NUM_CONTEXTS;
        dc_lps    = 1'b0;
        dc_move   = 1'b0;
        if (r_c < {8'h00, dc_qe}) begin
            // conditional exchange
            dc_lps  = !(dc_asub < dc_qe);
            dc_move = 1'b1;
        end else if (dc_asub < INTERVAL_MIN) begin
            dc_lps  = dc_asub < dc_qe;
            dc_move = 1'b1;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_a       = r_a;
        n_c       = r_c;
        n_ct      = r_ct;
        n_b       = r_b;
        n_markers = r_markers;
        n_rp      = r_rp;
        n_loaded  = r_loaded;
        n_n       = r_n;
        n_dec     = r_dec;
        n_item    = r_item;
        n_strobe  = 1'b0;
        n_result  = r_result;
        ctx_req   = '0;
        byte_req  = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    case (i_item.op)
                        OP_DECODE: begin
                            if (dc_ctx_ok) begin
                                ctx_req.rd_en   = 1'b1;
                                ctx_req.rd_addr = CTX_AW'(i_item.context_index);
                                n_state         = S_DEC;
                            end else begin
                                n_strobe          = 1'b1;
                                n_result.decision = 1'b0;
                            end
                        end
                        OP_APPEND: begin
                            if (r_loaded < CNT_W'(BUF_BYTES)) begin
                                byte_req.wr_en   = 1'b1;
                                byte_req.wr_addr = r_loaded[BUF_AW-1:0];
                                byte_req.wr_data = i_item.code_byte;
                                n_loaded         = r_loaded + CNT_W'(1);
                            end
                            n_strobe          = 1'b1;
                            n_result.decision = 1'b0;
                        end
                        OP_SET: begin
                            if (dc_ctx_ok) begin
                                ctx_req.wr_en   = 1'b1;
                                ctx_req.wr_addr = CTX_AW'(i_item.context_index);
                                ctx_req.wr_data = {i_item.mps_bit,
                                    (i_item.prob_index > LAST_STATE) ? LAST_STATE
                                                                     : i_item.prob_index};
                            end
                            n_strobe          = 1'b1;
                            n_result.decision = 1'b0;
                        end
                        OP_START: begin
                            n_rp             = '0;
                            n_markers        = '0;
                            n_c              = '0;
                            n_b              = '0;
                            n_ct             = '0;
                            byte_req.rd_en   = 1'b1;
                            byte_req.rd_addr = '0;
                            n_phase          = PH_INIT1;
                            n_state          = S_RF_USE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_DEC: begin
                if (r_c >= {8'h00, dc_qe}) begin
                    n_c = r_c - {8'h00, dc_qe};
                end
                n_a = (r_c < {8'h00, dc_qe}) ? dc_qe : dc_asub;
                if (!dc_move) begin
                    n_strobe          = 1'b1;
                    n_result.decision = dc_mps;
                    n_state           = S_IDLE;
                end else begin
                    ctx_req.wr_en   = 1'b1;
                    ctx_req.wr_addr = CTX_AW'(r_item.context_index);
                    if (dc_lps) begin
                        ctx_req.wr_data = {dc_mps ^ swap_mps(dc_idx), NLPS_TAB[dc_idx]};
                        n_dec           = ~dc_mps;
                    end else begin
                        ctx_req.wr_data = {dc_mps, NMPS_TAB[dc_idx]};
                        n_dec           = dc_mps;
                    end
                    n_n     = '0;
                    n_state = S_SHIFT;
                end
            end

            S_SHIFT: begin
                if (r_ct == 4'd0) begin
                    byte_req.rd_en   = 1'b1;
                    byte_req.rd_addr = r_rp[BUF_AW-1:0];
                    n_phase          = PH_RENORM;
                    n_state          = S_RF_USE;
                end else begin
                    n_a  = sh_a;
                    n_c  = sh_c;
                    n_ct = sh_ct;
                    n_n  = sh_n;
                    if (sh_done) begin
                        n_strobe          = 1'b1;
                        n_result.decision = r_dec;
                        n_state           = S_IDLE;
                    end
                end
            end

            S_RF_USE: begin
                n_b       = rf_b;
                n_rp      = rf_rp;
                n_markers = rf_mk;
                case (r_phase)
                    PH_INIT1: begin
                        n_c              = rf_c << rf_ct;
                        n_ct             = rf_ct;
                        byte_req.rd_en   = 1'b1;
                        byte_req.rd_addr = rf_rp[BUF_AW-1:0];
                        n_phase          = PH_INIT2;
                    end
                    PH_INIT2: begin
                        n_c               = rf_c << 7;
                        n_ct              = rf_ct - 4'd7;
                        n_a               = INTERVAL_MIN;
                        n_strobe          = 1'b1;
                        n_result.decision = 1'b0;
                        n_state           = S_IDLE;
                    end
                    default: begin
                        // refill followed by the pending shift
                        n_a  = sh_a;
                        n_c  = sh_c;
                        n_ct = sh_ct;
                        n_n  = sh_n;
                        if (sh_done) begin
                            n_strobe          = 1'b1;
                            n_result.decision = r_dec;
                            n_state           = S_IDLE;
                        end else begin
                            n_state = S_SHIFT;
                        end
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_strobe) begin
            n_result.marker_count = n_markers;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_INIT1;
            r_a       <= '0;
            r_c       <= '0;
            r_ct      <= '0;
            r_b       <= '0;
            r_markers <= '0;
            r_rp      <= '0;
            r_loaded  <= '0;
            r_n       <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_a       <= n_a;
            r_c       <= n_c;
            r_ct      <= n_ct;
            r_b       <= n_b;
            r_markers <= n_markers;
            r_rp      <= n_rp;
            r_loaded  <= n_loaded;
            r_n       <= n_n;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_dec    <= n_dec;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

FILE: rtl/core/mqd_checker.sv
// Port-level checks on the MQ decoder command and result timing.
module mqd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input mqd_pkg::t_in_item  i_item,
    input logic               o_strobe,
    input mqd_pkg::t_out_item o_result
);
    import mqd_pkg::*;

    // append and set words finish at once with a zero decision
    a_quick_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.op == OP_APPEND || i_item.op == OP_SET)
        |=> o_strobe && !o_result.decision)
        else $error("append/set word did not complete in one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while sequencer busy");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a started word");

    // a start word always runs its refill cycles
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.op == OP_START |=> busy && !o_strobe)
        else $error("start word skipped initialization");

endmodule

bind mq_arithmetic_decoder_core mqd_checker u_mqd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
